[rtl/sact_pkg.sv]
// Shared types and constants of the cache tag controller.
`default_nettype none
package sact_pkg;
	localparam logic [1:0] POL_LRU  = 2'd0;
	localparam logic [1:0] POL_FIFO = 2'd1;
	localparam logic [1:0] POL_LFU  = 2'd2;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_WAYS   = 2'd1;
	localparam logic [1:0] REG_INDEX  = 2'd2;
	localparam logic [1:0] REG_OFFSET = 2'd3;

	localparam int CFG_DATA_WIDTH = 5;
	localparam int CFG_IDX_WIDTH  = 2;

	typedef struct packed {
		logic [1:0] policy;
		logic [4:0] ways;
		logic [3:0] index_width;
		logic [3:0] offset_width;
	} cfg_t;
endpackage
`default_nettype wire

[rtl/sact_cfg_regs.sv]
// Configuration register file of the cache tag controller.
`default_nettype none
module sact_cfg_regs (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [sact_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  wire logic [sact_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output sact_pkg::cfg_t                             cfg
);
	import sact_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy       <= POL_LRU;
			cfg_q.ways         <= 5'd16;
			cfg_q.index_width  <= 4'd8;
			cfg_q.offset_width <= 4'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY: cfg_q.policy       <= cfg_data[1:0];
				REG_WAYS:   cfg_q.ways         <= cfg_data[4:0];
				REG_INDEX:  cfg_q.index_width  <= cfg_data[3:0];
				REG_OFFSET: cfg_q.offset_width <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

[rtl/set_assoc_cache_tag_controller_unit.sv]
// Top level of the write-back set-associative cache tag controller.
`default_nettype none
// Tag and replacement controller for a write-back, write-allocate cache. Each
// transaction on the input channel carries a byte address and a read/write
// flag; one result transaction reports hit, the way used, whether a dirty
// line was evicted and its tag. The set state (tag, valid, dirty and age of
// every way) lives in one synchronous memory row per set. An access first
// reads the row; then tags are compared and the victim is chosen while the
// new row is written back and the result is registered; the result is then
// held in the output register until taken. A new transaction is taken once
// the previous result has left the output register, so back-to-back accesses
// to one set never overlap. After reset the memory is cleared one set per
// cycle, and no transaction is accepted until it is cleared; configuration
// writes are taken at any time.
module set_assoc_cache_tag_controller_unit #(
	parameter int MAX_SETS   = 256,
	parameter int MAX_WAYS   = 16,
	parameter int ADDR_WIDTH = 32,
	parameter int AGE_WIDTH  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [sact_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  wire logic [sact_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                func,
	input  wire logic [31:0]                         byte_address,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     hit,
	output logic [3:0]                               way_used,
	output logic                                     dirty_evict,
	output logic [31:0]                              victim_tag
);
	import sact_pkg::*;

	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W   = $clog2(MAX_WAYS + 1);
	localparam int IW_LIM  = (MAX_SETS > 1) ? $clog2(MAX_SETS + 1) - 1 : 0;
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

	typedef struct packed {
		logic                  valid;
		logic                  dirty;
		logic [ADDR_WIDTH-1:0] tag;
		logic [AGE_WIDTH-1:0]  age;
	} line_t;
	typedef line_t [MAX_WAYS-1:0] row_t;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	cfg_t cfg;
	sact_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	row_t mem [MAX_SETS];
	row_t rd_row_s2;

	logic [1:0]            state_q;
	logic                  clr_q;
	logic [SET_W-1:0]      clr_set_q;
	logic                  wr_s1;
	logic [SET_W-1:0]      set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;

	// Address split with the clamped configuration. The shift sum needs five
	// bits, since offset and index widths together reach twenty-three.
	logic [3:0]            iw;
	logic [ADDR_WIDTH-1:0] addr;
	logic [ADDR_WIDTH-1:0] tag_c;
	logic [ADDR_WIDTH-1:0] set_c;
	always_comb begin
		iw = (cfg.index_width > 4'(IW_LIM)) ? 4'(IW_LIM) : cfg.index_width;
		addr = ADDR_WIDTH'(byte_address);
		tag_c = ADDR_WIDTH'(addr >> (5'(cfg.offset_width) + 5'(iw)));
		set_c = (addr >> cfg.offset_width) & ~({ADDR_WIDTH{1'b1}} << iw);
	end

	assign in_ready = (state_q == ST_IDLE) && !clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			clr_q     <= 1'b1;
			clr_set_q <= '0;
		end else begin
			if (clr_q) begin
				clr_set_q <= clr_set_q + 1'b1;
				if (clr_set_q == SET_W'(MAX_SETS - 1)) clr_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_READ;
				ST_READ: state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			wr_s1  <= func;
			set_s1 <= SET_W'(set_c);
			tag_s1 <= tag_c;
		end
	end

	// Hit search, fill search and victim choice on the row read.
	logic [CNT_W-1:0]     nways;
	logic [1:0]           pol;
	logic                 hit_c, found_c;
	logic [WAY_W-1:0]     hway, fway, vway, way_c;
	logic [AGE_WIDTH-1:0] best;
	row_t                 new_row;
	logic                 dev_c;
	logic [ADDR_WIDTH-1:0] vtag_c;
	// Victim comparison tree; node i holds the winner of the ways it covers.
	logic [AGE_WIDTH-1:0] t_age [MAX_WAYS];
	logic [WAY_W-1:0]     t_way [MAX_WAYS];
	logic                 t_en  [MAX_WAYS];

	function automatic logic [AGE_WIDTH-1:0] inc(input logic [AGE_WIDTH-1:0] a);
		inc = (a == AGE_MAX) ? a : a + 1'b1;
	endfunction

	always_comb begin
		nways = (cfg.ways == 5'd0) ? CNT_W'(1) :
			((32'(cfg.ways) > MAX_WAYS) ? CNT_W'(MAX_WAYS) : CNT_W'(cfg.ways));
		pol = (cfg.policy == POL_FIFO || cfg.policy == POL_LFU) ? cfg.policy : POL_LRU;
		hit_c = 1'b0; found_c = 1'b0;
		hway = '0; fway = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (CNT_W'(i) < nways) begin
				if (rd_row_s2[i].valid && rd_row_s2[i].tag == tag_s1) begin
					hit_c = 1'b1; hway = WAY_W'(i);
				end
				if (!rd_row_s2[i].valid) begin
					found_c = 1'b1; fway = WAY_W'(i);
				end
			end
		end
		// The lower way wins ties, so the tree picks the first maximum (or the
		// first minimum under LFU) among the searched ways.
		for (int i = 0; i < MAX_WAYS; i++) begin
			t_age[i] = rd_row_s2[i].age;
			t_way[i] = WAY_W'(i);
			t_en[i]  = (CNT_W'(i) < nways);
		end
		for (int s = 1; s < MAX_WAYS; s = s * 2) begin
			for (int i = 0; i + s < MAX_WAYS; i = i + 2 * s) begin
				if (t_en[i + s] && (!t_en[i] || ((pol == POL_LFU) ?
						(t_age[i + s] < t_age[i]) : (t_age[i + s] > t_age[i])))) begin
					t_age[i] = t_age[i + s];
					t_way[i] = t_way[i + s];
					t_en[i]  = 1'b1;
				end
			end
		end
		best = t_age[0];
		vway = t_way[0];
		way_c = hit_c ? hway : (found_c ? fway : vway);
		dev_c = !hit_c && !found_c && rd_row_s2[vway].dirty;
		vtag_c = dev_c ? rd_row_s2[vway].tag : '0;
		new_row = rd_row_s2;
		if (pol != POL_LFU) begin
			for (int i = 0; i < MAX_WAYS; i++)
				if (CNT_W'(i) < nways) new_row[i].age = inc(rd_row_s2[i].age);
		end
		if (hit_c) begin
			if (pol == POL_LRU) new_row[way_c].age = AGE_WIDTH'(1);
			else if (pol == POL_LFU) new_row[way_c].age = inc(rd_row_s2[way_c].age);
			if (wr_s1) new_row[way_c].dirty = 1'b1;
		end else begin
			new_row[way_c].valid = 1'b1;
			new_row[way_c].tag = tag_s1;
			new_row[way_c].dirty = wr_s1;
			new_row[way_c].age = (found_c || pol != POL_LFU) ? AGE_WIDTH'(1) : inc(best);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) mem[clr_set_q] <= '0;
		else if (state_q == ST_UPD) mem[set_s1] <= new_row;
		rd_row_s2 <= mem[set_s1];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			hit         <= hit_c;
			way_used    <= 4'(way_c);
			dirty_evict <= dev_c;
			victim_tag  <= 32'(vtag_c);
		end
	end

	assign out_valid = (state_q == ST_OUT);
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench of the set-associative cache tag controller.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import sact_pkg::*;

	typedef struct packed {
		logic        hit;
		logic [3:0]  way;
		logic        dirty_evict;
		logic [31:0] victim_tag;
	} lookup_t;

	// One row of the directed table. When check_now is set, the expected lookup
	// outcome is typed into the row and is compared against the model as well.
	typedef struct {
		logic        func;
		logic [31:0] addr;
		logic        check_now;
		lookup_t     want;
	} access_row_t;

	localparam int SETS = 256;
	localparam int WAYS = 16;
	localparam logic [15:0] AGE_TOP = 16'hFFFF;
	localparam logic FN_READ = 1'b0;
	localparam logic FN_WRITE = 1'b1;
	localparam int CYCLE_LIMIT = 800000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic [31:0] byte_address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [3:0] way_used;
	logic dirty_evict;
	logic [31:0] victim_tag;

	set_assoc_cache_tag_controller_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .byte_address(byte_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .way_used(way_used), .dirty_evict(dirty_evict),
		.victim_tag(victim_tag)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Shadow copy of the cache directory, indexed by set*WAYS + way.
	logic [31:0] shadow_tag [SETS*WAYS];
	logic        shadow_valid [SETS*WAYS];
	logic        shadow_dirty [SETS*WAYS];
	logic [15:0] shadow_age [SETS*WAYS];
	logic [1:0]  cur_policy;
	logic [4:0]  cur_ways;
	logic [3:0]  cur_index_w;
	logic [3:0]  cur_offset_w;

	lookup_t expected_lookups [$];
	int mismatches = 0;
	int lookups_seen = 0;
	int hits_seen = 0;
	int writebacks_seen = 0;
	longint cycles = 0;

	function automatic logic [15:0] sat_inc(logic [15:0] a);
		return (a == AGE_TOP) ? AGE_TOP : a + 16'd1;
	endfunction

	// Predicts one access and updates the shadow directory.
	function automatic lookup_t predict_lookup(logic wr, logic [31:0] addr);
		int nways, iw, ow, base, way;
		logic [1:0] pol;
		logic [31:0] tag;
		logic [15:0] best;
		bit found;
		lookup_t r;
		nways = cur_ways;
		if (nways < 1) nways = 1;
		if (nways > WAYS) nways = WAYS;
		iw = cur_index_w;
		if (iw > 8) iw = 8;
		ow = cur_offset_w;
		// A policy code of three behaves as LRU.
		pol = (cur_policy == POL_FIFO || cur_policy == POL_LFU) ? cur_policy : POL_LRU;
		tag = 32'(64'(addr) >> (ow + iw));
		base = int'((64'(addr) >> ow) & ((64'd1 << iw) - 1)) * WAYS;
		r = '0;
		way = 0;
		found = 1'b0;
		for (int i = 0; i < nways; i++)
			if (!found && shadow_valid[base+i] && shadow_tag[base+i] == tag) begin
				found = 1'b1;
				way = i;
			end
		if (found) begin
			r.hit = 1'b1;
			if (pol != POL_LFU)
				for (int i = 0; i < nways; i++) shadow_age[base+i] = sat_inc(shadow_age[base+i]);
			if (pol == POL_LRU) shadow_age[base+way] = 16'd1;
			else if (pol == POL_LFU) shadow_age[base+way] = sat_inc(shadow_age[base+way]);
			if (wr) shadow_dirty[base+way] = 1'b1;
		end else begin
			for (int i = 0; i < nways; i++)
				if (!found && !shadow_valid[base+i]) begin
					found = 1'b1;
					way = i;
				end
			if (found) begin
				if (pol != POL_LFU)
					for (int i = 0; i < nways; i++) shadow_age[base+i] = sat_inc(shadow_age[base+i]);
				shadow_valid[base+way] = 1'b1;
				shadow_age[base+way] = 16'd1;
			end else begin
				// Victim: first oldest way, or first least-used way under LFU.
				best = shadow_age[base];
				for (int i = 1; i < nways; i++)
					if (pol == POL_LFU ? shadow_age[base+i] < best : shadow_age[base+i] > best) begin
						best = shadow_age[base+i];
						way = i;
					end
				if (shadow_dirty[base+way]) begin
					r.dirty_evict = 1'b1;
					r.victim_tag = shadow_tag[base+way];
				end
				if (pol != POL_LFU) begin
					for (int i = 0; i < nways; i++) shadow_age[base+i] = sat_inc(shadow_age[base+i]);
					shadow_age[base+way] = 16'd1;
				end else begin
					shadow_age[base+way] = sat_inc(best);
				end
			end
			shadow_tag[base+way] = tag;
			shadow_dirty[base+way] = wr;
		end
		r.way = 4'(way);
		return r;
	endfunction

	task automatic report_mismatch(string what, lookup_t want, lookup_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: expected hit=%0b way=%0d dirty=%0b tag=%h, got hit=%0b way=%0d dirty=%0b tag=%h",
				what, want.hit, want.way, want.dirty_evict, want.victim_tag,
				got.hit, got.way, got.dirty_evict, got.victim_tag);
	endtask

	// Output monitor: sampled at the rising edge, compared with the oldest prediction.
	always @(posedge clk) begin
		lookup_t got, want;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			got = '{hit, way_used, dirty_evict, victim_tag};
			lookups_seen++;
			if (hit) hits_seen++;
			if (dirty_evict) writebacks_seen++;
			if (expected_lookups.size() == 0) begin
				report_mismatch("unexpected transaction", '0, got);
			end else begin
				want = expected_lookups.pop_front();
				if (got !== want) report_mismatch("lookup result", want, got);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, expected_lookups.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: random stall before each transaction, with stall-free stretches.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POLICY: cur_policy = val[1:0];
			REG_WAYS:   cur_ways = val[4:0];
			REG_INDEX:  cur_index_w = val[3:0];
			REG_OFFSET: cur_offset_w = val[3:0];
			default: ;
		endcase
	endtask

	// Waits until every prediction has been matched, plus a little settling time.
	task automatic drain;
		while (expected_lookups.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic [1:0] pol, logic [4:0] nw, logic [3:0] iw, logic [3:0] ow);
		drain();
		write_reg(REG_POLICY, 5'(pol));
		write_reg(REG_WAYS, nw);
		write_reg(REG_INDEX, 5'(iw));
		write_reg(REG_OFFSET, 5'(ow));
	endtask

	// Sends one transaction with a random lead gap; valid stays up until accepted.
	// The previous transaction drops valid at the falling edge where this task
	// starts, so the new one is raised no earlier than the next falling edge.
	task automatic send_access(logic wr, logic [31:0] addr, bit gap_on);
		int gap;
		gap = gap_on ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10)) : 0;
		repeat (gap + 1) @(negedge clk);
		in_valid <= 1'b1;
		func <= wr;
		byte_address <= addr;
		do @(posedge clk); while (!in_ready);
		expected_lookups.push_back(predict_lookup(wr, addr));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Address with a tag drawn from a small pool so that sets fill, hit and evict.
	function automatic logic [31:0] pooled_addr(int tag_pool);
		logic [31:0] a;
		int ow, iw;
		ow = cur_offset_w;
		iw = (cur_index_w > 8) ? 8 : cur_index_w;
		a = 32'($urandom_range(0, tag_pool - 1)) << (ow + iw);
		a |= (32'($urandom_range(0, 3)) << ow) & ((32'd1 << (ow + iw)) - 1);
		a |= $urandom & ((32'd1 << ow) - 1);
		return a;
	endfunction

	access_row_t directed [$];

	initial begin
		access_row_t row;
		int phase_items;
		logic [1:0] pol;
		for (int i = 0; i < SETS*WAYS; i++) begin
			shadow_tag[i] = '0; shadow_valid[i] = 1'b0;
			shadow_dirty[i] = 1'b0; shadow_age[i] = '0;
		end
		cur_policy = POL_LRU; cur_ways = 5'd16; cur_index_w = 4'd8; cur_offset_w = 4'd5;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset configuration: first fill, hit, write hit,
		// extremes of the address, then a second set of tags that forces eviction.
		directed.push_back('{FN_READ, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0, 32'd0}});
		directed.push_back('{FN_WRITE, 32'h0000_001F, 1'b1, '{1'b1, 4'd0, 1'b0, 32'd0}});
		directed.push_back('{FN_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 1'b0, 32'd0}});
		directed.push_back('{FN_READ, 32'hFFFF_FFE0, 1'b1, '{1'b1, 4'd0, 1'b0, 32'd0}});
		for (int t = 1; t <= 17; t++)
			directed.push_back('{(t % 2 == 1) ? FN_WRITE : FN_READ,
				32'(t) << 13, 1'b0, '0});
		foreach (directed[i]) begin
			row = directed[i];
			send_access(row.func, row.addr, 1'b0);
			if (row.check_now && expected_lookups[$] !== row.want)
				report_mismatch("directed row", row.want, expected_lookups[$]);
		end

		// Extreme and out-of-range settings: one way, no index bits, no offset,
		// zero ways, policy code three, an oversized index width and way count.
		configure(2'd3, 5'd0, 4'd15, 4'd0);
		for (int i = 0; i < 20; i++) send_access(1'($urandom), pooled_addr(3), 1'b1);
		configure(POL_LFU, 5'd31, 4'd0, 4'd8);
		for (int i = 0; i < 20; i++) send_access(1'($urandom), pooled_addr(20), 1'b1);

		// Hold off until everything has come back once.
		drain();

		// Random phases across policies and geometries, including all ways and one way.
		for (int p = 0; p < 12; p++) begin
			pol = 2'($urandom_range(0, 3));
			case (p % 4)
				0: configure(pol, 5'd16, 4'($urandom_range(0, 2)), 4'($urandom_range(0, 8)));
				1: configure(pol, 5'd1, 4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)));
				default: configure(pol, 5'($urandom_range(1, 16)), 4'($urandom_range(0, 3)),
					4'($urandom_range(0, 15)));
			endcase
			phase_items = 100;
			for (int i = 0; i < phase_items; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_access(1'($urandom), $urandom, 1'b1);
				else
					send_access(1'($urandom), pooled_addr(cur_ways + 4), $urandom_range(0, 4) != 0);
			end
		end

		drain();
		repeat (20) @(negedge clk);
		$display("Covered %0d lookups: %0d hits, %0d dirty writebacks, all policies",
			lookups_seen, hits_seen, writebacks_seen);
		$display("with one to sixteen ways and index widths from zero to oversized.");
		if (mismatches == 0 && expected_lookups.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_lookups.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
rtl/sact_pkg.sv
rtl/sact_cfg_regs.sv
rtl/set_assoc_cache_tag_controller_unit.sv
tb/sv/tb.sv
